/* rtl/ppuri_pkg.sv */
// Shared types, register codes and helpers for the video unit register interface.
package ppuri_pkg;

  localparam int NT_BYTES = 1024;
  localparam int NT_SHIFT = $clog2(NT_BYTES);

  localparam logic [2:0] CMD_READ      = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_VBLANK    = 3'd2;
  localparam logic [2:0] CMD_FRAME_CLR = 3'd3;
  localparam logic [2:0] CMD_SPR0_HIT  = 3'd4;
  localparam logic [2:0] CMD_OVERFLOW  = 3'd5;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [2:0] MIR_HORZ      = 3'd0;
  localparam logic [2:0] MIR_VERT      = 3'd1;
  localparam logic [2:0] MIR_SINGLE_LO = 3'd2;
  localparam logic [2:0] MIR_SINGLE_HI = 3'd3;
  localparam logic [2:0] MIR_FOUR      = 3'd4;

  localparam logic [7:0] PAL_MASK_GREY = 8'h30;
  localparam logic [7:0] PAL_MASK_FULL = 8'h3F;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_STATUS,
    RD_SPRITE,
    RD_CHR,
    RD_NT,
    RD_PAL
  } rd_src_t;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] chr_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x;
    logic        chr_write_valid;
    logic [7:0]  chr_write_data;
  } out_item_t;

  typedef struct packed {
    logic                nt_we;
    logic                nt_re;
    logic [1:0]          nt_page;
    logic [NT_SHIFT-1:0] nt_offset;
    logic                pal_we;
    logic                pal_re;
    logic [4:0]          pal_addr;
    logic                spr_we;
    logic                spr_re;
    logic [7:0]          spr_addr;
    logic [7:0]          wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] nt;
    logic [7:0] pal;
    logic [7:0] spr;
  } mem_rdata_t;

  typedef struct packed {
    rd_src_t     rd_src;
    logic [2:0]  status_bits;
    logic        grey;
    logic [7:0]  chr_data;
    logic        nmi;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x;
    logic        chr_write_valid;
    logic [7:0]  chr_write_data;
  } stage_info_t;

  function automatic logic [4:0] pal_index(logic [4:0] p);
    return (p[1:0] == 2'b00) ? {1'b0, p[3:0]} : p;
  endfunction

endpackage

/* rtl/ppuri_if.sv */
// Valid/ready channels for request and response transactions.
interface ppuri_req_if;
  ppuri_pkg::in_item_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppuri_rsp_if;
  ppuri_pkg::out_item_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ppuri_regs.sv */
// Register file and decode: updates control state and issues memory accesses.
module ppuri_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  ppuri_pkg::in_item_t    item,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_wdata,
  output ppuri_pkg::mem_req_t    mem_req,
  output ppuri_pkg::stage_info_t info
);
  import ppuri_pkg::*;

  logic [2:0]  mirror_sel;
  logic [7:0]  ctrl, ctrl_next;
  logic [7:0]  mask, mask_next;
  logic [2:0]  status, status_next;
  logic [14:0] cur_addr, cur_addr_next;
  logic [14:0] temp_addr, temp_addr_next;
  logic [2:0]  fine, fine_next;
  logic        toggle, toggle_next;
  logic [7:0]  spr_addr, spr_addr_next;
  logic        nmi, nmi_next;

  logic [13:0] vaddr;
  logic        is_chr;
  logic        is_pal;
  logic [1:0]  page;
  logic [14:0] inc;

  assign vaddr  = cur_addr[13:0];
  assign is_chr = !vaddr[13];
  assign is_pal = (vaddr[13:8] == 6'h3F);
  assign inc    = ctrl[2] ? 15'd32 : 15'd1;

  always_comb begin
    case (mirror_sel)
      MIR_HORZ:      page = {1'b0, vaddr[11]};
      MIR_VERT:      page = {1'b0, vaddr[10]};
      MIR_SINGLE_HI: page = 2'd1;
      MIR_FOUR:      page = vaddr[11:10];
      default:       page = 2'd0;
    endcase
  end

  always_comb begin
    ctrl_next      = ctrl;
    mask_next      = mask;
    status_next    = status;
    cur_addr_next  = cur_addr;
    temp_addr_next = temp_addr;
    fine_next      = fine;
    toggle_next    = toggle;
    spr_addr_next  = spr_addr;
    nmi_next       = nmi;

    mem_req           = '0;
    mem_req.nt_page   = page;
    mem_req.nt_offset = vaddr[NT_SHIFT-1:0];
    mem_req.pal_addr  = pal_index(vaddr[4:0]);
    mem_req.spr_addr  = spr_addr;
    mem_req.wdata     = item.write_data;

    info                 = '0;
    info.rd_src          = RD_ZERO;
    info.status_bits     = status;
    info.grey            = mask[0];
    info.chr_data        = item.chr_data;

    if (accept) begin
      case (item.command)
        CMD_READ: begin
          case (item.reg_index)
            REG_STATUS: begin
              info.rd_src = RD_STATUS;
              status_next = {1'b0, status[1:0]};
              nmi_next    = 1'b0;
              toggle_next = 1'b0;
            end
            REG_SPR_DATA: begin
              info.rd_src    = RD_SPRITE;
              mem_req.spr_re = 1'b1;
            end
            REG_DATA: begin
              if (is_chr) begin
                info.rd_src = RD_CHR;
              end else if (!is_pal) begin
                info.rd_src   = RD_NT;
                mem_req.nt_re = 1'b1;
              end else begin
                info.rd_src    = RD_PAL;
                mem_req.nt_re  = 1'b1;
                mem_req.pal_re = 1'b1;
              end
              cur_addr_next = cur_addr + inc;
            end
            default: begin
              info.rd_src = RD_ZERO;
            end
          endcase
        end
        CMD_WRITE: begin
          case (item.reg_index)
            REG_CTRL: begin
              ctrl_next = item.write_data;
              if (!ctrl[7]) begin
                nmi_next = item.write_data[7] & status[2];
              end
              temp_addr_next[11:10] = item.write_data[1:0];
            end
            REG_MASK: begin
              mask_next = item.write_data;
            end
            REG_SPR_ADDR: begin
              spr_addr_next = item.write_data;
            end
            REG_SPR_DATA: begin
              mem_req.spr_we = 1'b1;
              spr_addr_next  = spr_addr + 8'd1;
            end
            REG_SCROLL: begin
              if (!toggle) begin
                fine_next           = item.write_data[2:0];
                temp_addr_next[4:0] = item.write_data[7:3];
                toggle_next         = 1'b1;
              end else begin
                temp_addr_next = {item.write_data[2:0], temp_addr[11:10],
                                  item.write_data[7:3], temp_addr[4:0]};
                toggle_next    = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!toggle) begin
                temp_addr_next = {1'b0, item.write_data[5:0], temp_addr[7:0]};
                toggle_next    = 1'b1;
              end else begin
                temp_addr_next = {temp_addr[14:8], item.write_data};
                cur_addr_next  = {temp_addr[14:8], item.write_data};
                toggle_next    = 1'b0;
              end
            end
            REG_DATA: begin
              if (is_chr) begin
                info.chr_write_valid = 1'b1;
                info.chr_write_data  = item.write_data;
              end else if (!is_pal) begin
                mem_req.nt_we = 1'b1;
              end else begin
                mem_req.pal_we = 1'b1;
              end
              cur_addr_next = cur_addr + inc;
            end
            default: begin
              toggle_next = toggle;
            end
          endcase
        end
        CMD_VBLANK: begin
          status_next[2] = 1'b1;
          nmi_next       = ctrl[7];
        end
        CMD_FRAME_CLR: begin
          status_next = 3'd0;
          nmi_next    = 1'b0;
        end
        CMD_SPR0_HIT: begin
          status_next[1] = 1'b1;
        end
        CMD_OVERFLOW: begin
          status_next[0] = 1'b1;
        end
        default: begin
          status_next = status;
        end
      endcase
    end

    info.nmi       = nmi_next;
    info.vram_addr = cur_addr_next;
    info.fine_x    = fine_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_sel <= MIR_HORZ;
      ctrl       <= '0;
      mask       <= '0;
      status     <= '0;
      cur_addr   <= '0;
      temp_addr  <= '0;
      fine       <= '0;
      toggle     <= 1'b0;
      spr_addr   <= '0;
      nmi        <= 1'b0;
    end else begin
      if (cfg_we) begin
        mirror_sel <= cfg_wdata;
      end
      ctrl      <= ctrl_next;
      mask      <= mask_next;
      status    <= status_next;
      cur_addr  <= cur_addr_next;
      temp_addr <= temp_addr_next;
      fine      <= fine_next;
      toggle    <= toggle_next;
      spr_addr  <= spr_addr_next;
      nmi       <= nmi_next;
    end
  end

endmodule

/* rtl/ppuri_mem.sv */
// Nametable, palette and sprite memories with the post-reset clearing sweep.
module ppuri_mem #(
  parameter int NAMETABLE_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ppuri_pkg::mem_req_t   req,
  output logic                  ready,
  output ppuri_pkg::mem_rdata_t rdata
);
  import ppuri_pkg::*;

  localparam int NT_DEPTH = NAMETABLE_COUNT * NT_BYTES;
  localparam int NT_AW    = $clog2(NT_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  clr_state_t       state;
  logic [NT_AW-1:0] clr_cnt;
  logic             clearing;

  logic [7:0] nt_mem  [NT_DEPTH];
  logic [7:0] pal_mem [32];
  logic [7:0] spr_mem [256];

  logic [7:0] nt_rd;
  logic [7:0] pal_rd;
  logic [7:0] spr_rd;

  logic [1:0]       page;
  logic [NT_AW-1:0] nt_addr;

  assign clearing = (state == ST_CLEAR);
  assign ready    = (state == ST_RUN);
  assign rdata    = {nt_rd, pal_rd, spr_rd};

  assign page = (3'(req.nt_page) >= 3'(NAMETABLE_COUNT))
              ? 2'(3'(req.nt_page) - 3'(NAMETABLE_COUNT)) : req.nt_page;
  assign nt_addr = (NT_AW'(page) << NT_SHIFT) | NT_AW'(req.nt_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NT_AW'(NT_DEPTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      nt_mem[clr_cnt] <= 8'h00;
    end else if (req.nt_we) begin
      nt_mem[nt_addr] <= req.wdata;
    end
    if (req.nt_re) begin
      nt_rd <= nt_mem[nt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      pal_mem[clr_cnt[4:0]] <= 8'h00;
    end else if (req.pal_we) begin
      pal_mem[req.pal_addr] <= req.wdata;
    end
    if (req.pal_re) begin
      pal_rd <= pal_mem[req.pal_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      spr_mem[clr_cnt[7:0]] <= 8'h00;
    end else if (req.spr_we) begin
      spr_mem[req.spr_addr] <= req.wdata;
    end
    if (req.spr_re) begin
      spr_rd <= spr_mem[req.spr_addr];
    end
  end

endmodule

/* rtl/ppuri_result.sv */
// Result stage: read buffer update, read data select and output register.
module ppuri_result (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  ppuri_pkg::stage_info_t info,
  input  ppuri_pkg::mem_rdata_t  rdata,
  output logic                   stage_ready,
  ppuri_rsp_if.source            response
);
  import ppuri_pkg::*;

  logic        s1_valid;
  stage_info_t s1_info;
  logic        move;
  logic [7:0]  read_buffer, read_buffer_next;
  logic [7:0]  rd;
  out_item_t   result;
  logic        out_valid;

  assign move        = s1_valid && (!out_valid || response.ready);
  assign stage_ready = !s1_valid || move;

  always_comb begin
    rd               = 8'h00;
    read_buffer_next = read_buffer;
    case (s1_info.rd_src)
      RD_STATUS: begin
        rd = {s1_info.status_bits, read_buffer[4:0]};
      end
      RD_SPRITE: begin
        rd = rdata.spr;
      end
      RD_CHR: begin
        rd               = read_buffer;
        read_buffer_next = s1_info.chr_data;
      end
      RD_NT: begin
        rd               = read_buffer;
        read_buffer_next = rdata.nt;
      end
      RD_PAL: begin
        rd               = rdata.pal & (s1_info.grey ? PAL_MASK_GREY : PAL_MASK_FULL);
        read_buffer_next = rdata.nt;
      end
      default: begin
        rd = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      read_buffer <= 8'h00;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        out_valid   <= 1'b1;
        read_buffer <= read_buffer_next;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_info <= info;
    end
    if (move) begin
      result.read_data       <= rd;
      result.nmi_request     <= s1_info.nmi;
      result.vram_addr       <= s1_info.vram_addr;
      result.fine_x          <= s1_info.fine_x;
      result.chr_write_valid <= s1_info.chr_write_valid;
      result.chr_write_data  <= s1_info.chr_write_data;
    end
  end

  assign response.valid = out_valid;
  assign response.data  = result;

endmodule

/* rtl/ppu_cpu_register_interface.sv */
// CPU-facing register interface of a tile video unit.
// One transaction is accepted per clock while request.ready is high, and each
// yields exactly one response: the accept edge issues the memory read and updates
// control, scroll and address registers, then the result stage forms the read data
// from the registered memory output and the read buffer and loads the output register.
// After reset a clearing sweep zeroes the nametable, palette and sprite memories
// one entry per cycle over the nametable memory depth of NAMETABLE_COUNT * 1024
// entries; request.ready stays low during it, while mirroring mode writes
// on cfg_we are taken at any time. request.ready also drops when both the
// result stage and the output register hold a response that is not taken.
module ppu_cpu_register_interface #(
  parameter int NAMETABLE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  ppuri_req_if.sink   request,
  ppuri_rsp_if.source response
);
  import ppuri_pkg::*;

  mem_req_t    mem_req;
  mem_rdata_t  mem_rdata;
  stage_info_t info;
  logic        mem_ready;
  logic        stage_ready;
  logic        accept;

  assign request.ready = mem_ready && stage_ready;
  assign accept        = request.valid && request.ready;

  ppuri_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (request.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .info      (info)
  );

  ppuri_mem #(
    .NAMETABLE_COUNT (NAMETABLE_COUNT)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .ready (mem_ready),
    .rdata (mem_rdata)
  );

  ppuri_result u_result (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .info        (info),
    .rdata       (mem_rdata),
    .stage_ready (stage_ready),
    .response    (response)
  );

endmodule

/* verif/ppuri_register_checker.sv */
// Predicts every register interface response and compares it with the block's output.
module ppuri_register_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  ppuri_req_if       request,
  ppuri_rsp_if       response,
  output int         responses_due,
  output int         mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppuri_pkg::*;

  logic [2:0]  mirror_mode;
  logic [7:0]  ctrl;
  logic [7:0]  mask;
  logic [2:0]  status;
  logic [14:0] vaddr;
  logic [14:0] taddr;
  logic [2:0]  fine;
  logic        toggle;
  logic [7:0]  data_buf;
  logic [7:0]  spr_ptr;
  logic        nmi;
  logic [7:0]  oam [256];
  logic [7:0]  palette [32];
  logic [7:0]  nametable [4096];
  out_item_t   pending_responses [$];

  function automatic logic [11:0] nametable_slot(logic [13:0] a);
    logic [1:0] page;
    case (mirror_mode)
      MIR_HORZ:      page = {1'b0, a[11]};
      MIR_VERT:      page = {1'b0, a[10]};
      MIR_SINGLE_HI: page = 2'd1;
      MIR_FOUR:      page = a[11:10];
      default:       page = 2'd0;
    endcase
    return {page, a[9:0]};
  endfunction

  function automatic logic [4:0] palette_slot(logic [13:0] a);
    return (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

  function automatic logic [7:0] vram_fetch(logic [13:0] a, logic [7:0] chr);
    if (a < 14'h2000) return chr;
    if (a < 14'h3F00) return nametable[nametable_slot(a)];
    return palette[palette_slot(a)] & (mask[0] ? PAL_MASK_GREY : PAL_MASK_FULL);
  endfunction

  function automatic out_item_t predict_register_access(in_item_t t);
    out_item_t   r;
    logic [13:0] a;
    logic        was_enabled;
    r = '0;
    a = vaddr[13:0];
    case (t.command)
      CMD_READ: begin
        case (t.reg_index)
          REG_STATUS: begin
            r.read_data = {status, data_buf[4:0]};
            status[2] = 1'b0;
            nmi = 1'b0;
            toggle = 1'b0;
          end
          REG_SPR_DATA: r.read_data = oam[spr_ptr];
          REG_DATA: begin
            r.read_data = data_buf;
            data_buf = vram_fetch(a, t.chr_data);
            // palette data bypasses the buffer, which refills from the nametable below
            if (a >= 14'h3F00) begin
              r.read_data = data_buf;
              data_buf = vram_fetch(a - 14'h1000, t.chr_data);
            end
            vaddr = vaddr + (ctrl[2] ? 15'd32 : 15'd1);
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (t.reg_index)
          REG_CTRL: begin
            was_enabled = ctrl[7];
            ctrl = t.write_data;
            if (!was_enabled) nmi = ctrl[7] & status[2];
            taddr[11:10] = t.write_data[1:0];
          end
          REG_MASK: mask = t.write_data;
          REG_SPR_ADDR: spr_ptr = t.write_data;
          REG_SPR_DATA: begin
            oam[spr_ptr] = t.write_data;
            spr_ptr = spr_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle) begin
              fine = t.write_data[2:0];
              taddr[4:0] = t.write_data[7:3];
            end else begin
              taddr = {t.write_data[2:0], taddr[11:10], t.write_data[7:3], taddr[4:0]};
            end
            toggle = !toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              taddr = {1'b0, t.write_data[5:0], taddr[7:0]};
            end else begin
              taddr = {taddr[14:8], t.write_data};
              vaddr = taddr;
            end
            toggle = !toggle;
          end
          REG_DATA: begin
            if (a < 14'h2000) begin
              r.chr_write_valid = 1'b1;
              r.chr_write_data = t.write_data;
            end else if (a < 14'h3F00) begin
              nametable[nametable_slot(a)] = t.write_data;
            end else begin
              palette[palette_slot(a)] = t.write_data;
            end
            vaddr = vaddr + (ctrl[2] ? 15'd32 : 15'd1);
          end
          default: ;
        endcase
      end
      CMD_VBLANK: begin
        status[2] = 1'b1;
        nmi = ctrl[7];
      end
      CMD_FRAME_CLR: begin
        status = 3'b000;
        nmi = 1'b0;
      end
      CMD_SPR0_HIT: status[1] = 1'b1;
      CMD_OVERFLOW: status[0] = 1'b1;
      default: ;
    endcase
    r.nmi_request = nmi;
    r.vram_addr = vaddr;
    r.fine_x = fine;
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [14:0] want, logic [14:0] got);
    if (got === want) return 0;
    $display("%0t: %s expected %h actual %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        errs;
    if (rst) begin
      mirror_mode = MIR_HORZ;
      ctrl = '0;
      mask = '0;
      status = '0;
      vaddr = '0;
      taddr = '0;
      fine = '0;
      toggle = 1'b0;
      data_buf = '0;
      spr_ptr = '0;
      nmi = 1'b0;
      foreach (oam[i]) oam[i] = '0;
      foreach (palette[i]) palette[i] = '0;
      foreach (nametable[i]) nametable[i] = '0;
      pending_responses.delete();
      responses_due <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_we) mirror_mode = cfg_wdata;
      if (response.valid && response.ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: response expected none actual %h", $time, response.data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_responses.pop_front();
          errs = 0;
          errs += field_mismatch("read_data", 15'(want.read_data),
                                 15'(response.data.read_data));
          errs += field_mismatch("nmi_request", 15'(want.nmi_request),
                                 15'(response.data.nmi_request));
          errs += field_mismatch("vram_addr", want.vram_addr, response.data.vram_addr);
          errs += field_mismatch("fine_x", 15'(want.fine_x), 15'(response.data.fine_x));
          errs += field_mismatch("chr_write_valid", 15'(want.chr_write_valid),
                                 15'(response.data.chr_write_valid));
          errs += field_mismatch("chr_write_data", 15'(want.chr_write_data),
                                 15'(response.data.chr_write_data));
          if (errs != 0) mismatch_count <= mismatch_count + 1;
        end
      end
      if (request.valid && request.ready) begin
        pending_responses.push_back(predict_register_access(request.data));
      end
      responses_due <= pending_responses.size();
    end
  end

endmodule

/* verif/ppu_cpu_register_interface_test.sv */
// Top of the register interface testbench: clock, reset, stimulus and verdict.
module ppu_cpu_register_interface_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppuri_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [2:0] MIR_SPARE_5 = 3'd5;
  localparam logic [2:0] MIR_SPARE_7 = 3'd7;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  int         sender_idle_pct = 0;
  int         receiver_idle_pct = 0;
  int         hold_requests = 0;
  int         items_sent = 0;
  int         responses_due;
  int         mismatch_count;

  ppuri_req_if req_ch();
  ppuri_rsp_if rsp_ch();

  ppu_cpu_register_interface i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .request  (req_ch),
    .response (rsp_ch)
  );

  ppuri_register_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .request       (req_ch),
    .response      (rsp_ch),
    .responses_due (responses_due),
    .mismatch_count(mismatch_count)
  );

  always #5ns clk = ~clk;

  task automatic send_access(logic [2:0] cmd, logic [2:0] idx, logic [7:0] wdata);
    in_item_t t;
    t.command = cmd;
    t.reg_index = idx;
    t.write_data = wdata;
    t.chr_data = 8'($urandom_range(0, 255));
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (responses_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_burst();
    logic [7:0] hi;
    int         n;
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 3))
          0:       hi = 8'($urandom_range(8'h00, 8'h1F));
          1:       hi = 8'($urandom_range(8'h20, 8'h3E));
          2:       hi = 8'h3F;
          default: hi = 8'($urandom_range(0, 255));
        endcase
        send_access(CMD_READ, REG_STATUS, 8'h00);
        send_access(CMD_WRITE, REG_ADDR, hi);
        send_access(CMD_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
        repeat (n) begin
          send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, REG_DATA,
                      8'($urandom_range(0, 255)));
        end
      end
      3: begin
        send_access(CMD_READ, REG_STATUS, 8'h00);
        send_access(CMD_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
        send_access(CMD_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
      end
      4: begin
        hi = 8'($urandom_range(0, 255));
        send_access(CMD_WRITE, REG_SPR_ADDR, hi);
        repeat (n) send_access(CMD_WRITE, REG_SPR_DATA, 8'($urandom_range(0, 255)));
        send_access(CMD_WRITE, REG_SPR_ADDR, hi);
        repeat (n) begin
          send_access(CMD_READ, REG_SPR_DATA, 8'h00);
          send_access(CMD_WRITE, REG_SPR_ADDR, hi + 8'($urandom_range(0, 7)));
        end
      end
      5: begin
        send_access(CMD_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
        send_access(CMD_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
      end
      6: begin
        repeat ($urandom_range(1, 4)) begin
          send_access(3'($urandom_range(CMD_VBLANK, CMD_OVERFLOW)), REG_STATUS, 8'h00);
        end
        if ($urandom_range(0, 1)) begin
          send_access(CMD_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
        end
        send_access(CMD_READ, REG_STATUS, 8'h00);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          send_access(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  initial begin
    logic [2:0] mode_plan [8];
    int         idle_plan [8];
    int         target;
    // modes 7 and 5 are undefined and act as single screen low
    mode_plan = '{MIR_HORZ, MIR_VERT, MIR_SINGLE_LO, MIR_SINGLE_HI, MIR_FOUR,
                  MIR_SPARE_7, MIR_SPARE_5, MIR_FOUR};
    idle_plan = '{25, 0, 10, 50, 20, 5, 35, 0};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= MIR_HORZ;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      cfg_we <= 1'b1;
      cfg_wdata <= mode_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      sender_idle_pct = idle_plan[ph];
      receiver_idle_pct = idle_plan[ph];
      target = items_sent + 205;
      if (ph == 0) begin
        send_access(CMD_WRITE, REG_CTRL, 8'h80);
        send_access(CMD_VBLANK, REG_CTRL, 8'h00);
        send_access(CMD_WRITE, REG_CTRL, 8'h00);
        send_access(CMD_WRITE, REG_CTRL, 8'h87);
        send_access(CMD_SPR0_HIT, REG_CTRL, 8'h00);
        send_access(CMD_OVERFLOW, REG_CTRL, 8'h00);
        send_access(CMD_READ, REG_STATUS, 8'h00);
        send_access(CMD_FRAME_CLR, REG_CTRL, 8'h00);
        send_access(CMD_SPARE_6, REG_DATA, 8'hFF);
        send_access(CMD_SPARE_7, REG_DATA, 8'hFF);
        send_access(CMD_WRITE, REG_SCROLL, 8'hFF);
        send_access(CMD_WRITE, REG_SCROLL, 8'hFF);
        send_access(CMD_WRITE, REG_ADDR, 8'hFF);
        send_access(CMD_WRITE, REG_ADDR, 8'hFF);
        send_access(CMD_WRITE, REG_DATA, 8'h3F);
        send_access(CMD_WRITE, REG_DATA, 8'hAA);
        send_access(CMD_WRITE, REG_MASK, 8'h01);
        send_access(CMD_WRITE, REG_ADDR, 8'h3F);
        send_access(CMD_WRITE, REG_ADDR, 8'h10);
        send_access(CMD_WRITE, REG_DATA, 8'hFF);
        send_access(CMD_WRITE, REG_ADDR, 8'h3F);
        send_access(CMD_WRITE, REG_ADDR, 8'h00);
        send_access(CMD_READ, REG_DATA, 8'h00);
        send_access(CMD_WRITE, REG_SPR_ADDR, 8'hFF);
        send_access(CMD_WRITE, REG_SPR_DATA, 8'h5A);
        send_access(CMD_READ, REG_SPR_DATA, 8'h00);
        send_access(CMD_READ, REG_CTRL, 8'h00);
        send_access(CMD_WRITE, REG_STATUS, 8'hFF);
      end
      if (ph == 1) hold_requests++;
      if (ph == 3) begin
        // walk the video address past its 15-bit limit in steps of 32
        send_access(CMD_WRITE, REG_CTRL, 8'h04);
        send_access(CMD_READ, REG_STATUS, 8'h00);
        send_access(CMD_WRITE, REG_ADDR, 8'h3F);
        send_access(CMD_WRITE, REG_ADDR, 8'hE0);
        repeat (520) begin
          send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, REG_DATA,
                      8'($urandom_range(0, 255)));
        end
      end
      while (items_sent < target) random_burst();
    end
    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int holds_served;
    holds_served = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        rsp_ch.ready <= 1'b0;
        repeat (100) @(posedge clk);
      end else if (receiver_idle_pct > 0 && $urandom_range(0, 99) < receiver_idle_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* ppu_cpu_register_interface.f */
rtl/ppuri_pkg.sv
rtl/ppuri_if.sv
rtl/ppuri_regs.sv
rtl/ppuri_mem.sv
rtl/ppuri_result.sv
rtl/ppu_cpu_register_interface.sv
verif/ppuri_register_checker.sv
verif/ppu_cpu_register_interface_test.sv
